>>> rtl/core/pidc_pkg.sv
// Shared constants, payload types and helper types for the PID position controller.
`default_nettype none

package pidc_pkg;

   localparam int POSITION_BITS  = 16;
   localparam int DRIVE_LIMIT_MV = 12000;

   localparam int EL_W     = 16;
   localparam int GAIN_W   = 16;
   localparam int TGT_W    = 16;
   localparam int TMO_W    = 16;
   localparam int FLOOR_W  = 32;
   localparam int CEIL_W   = 31;
   localparam int INTEG_W  = 32;
   localparam int TIME_W   = 17;
   localparam int DRIVE_W  = 15;
   localparam int REASON_W = 2;

   localparam int ERR_W  = POSITION_BITS + 1;
   localparam int DIFF_W = POSITION_BITS + 2;

   // serial multiplier: A is parallel, B is consumed one bit a cycle
   localparam int MUL_A_W    = INTEG_W;
   localparam int MUL_B_W    = (DIFF_W > GAIN_W) ? DIFF_W : GAIN_W;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int MUL_CNT_W  = $clog2(MUL_B_W + 1);
   localparam int DIV_CNT_W  = $clog2(PROD_W + 1);

   localparam int EI_W  = ERR_W + EL_W;
   localparam int ACC_W = ((INTEG_W > EI_W + 1) ? INTEG_W : EI_W + 1) + 1;
   localparam int DRV_W = PROD_W + 2;

   localparam int INTEG_SCALE = 1000;
   localparam int DERIV_SCALE = 1000;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CEILING  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT  = 3'd6;

   localparam logic signed [TGT_W-1:0]   TARGET_RST  = 16'sd0;
   localparam logic [GAIN_W-1:0]         GAIN_P_RST  = 16'd100;
   localparam logic [GAIN_W-1:0]         GAIN_I_RST  = 16'd125;
   localparam logic [GAIN_W-1:0]         GAIN_D_RST  = 16'd75;
   localparam logic signed [FLOOR_W-1:0] FLOOR_RST   = -32'sd100000;
   localparam logic [CEIL_W-1:0]         CEILING_RST = 31'd100000;
   localparam logic [TMO_W-1:0]          TIMEOUT_RST = 16'd2000;

   localparam logic [REASON_W-1:0] REASON_RUN     = 2'd0;
   localparam logic [REASON_W-1:0] REASON_TIMEOUT = 2'd1;
   localparam logic [REASON_W-1:0] REASON_SETTLED = 2'd2;

   typedef logic signed [ERR_W-1:0]   err_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;
   typedef logic signed [ACC_W-1:0]   acc_type;
   typedef logic signed [DRV_W-1:0]   drv_type;
   typedef logic signed [INTEG_W-1:0] integ_type;
   typedef logic [TIME_W-1:0]         time_type;

   typedef struct packed {
      logic signed [POSITION_BITS-1:0] position;
      logic [EL_W-1:0]                 elapsed_ms;
      logic                            first_sample;
   } req_type;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive_mv;
      logic                      done_res;
      logic [REASON_W-1:0]       end_reason;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

`default_nettype wire

>>> rtl/core/pid_position_controller.sv
// Each transaction makes five 18-step passes through the shared shift-add multiplier and
//   up to two 50-step passes through the restoring divider; the second divider pass is
//   skipped when elapsed_ms is 0.
// A finished result waits in the rsp register while the next transaction is accepted.
// Reset (synchronous): registers to their defaults, controller state cleared, both channels idle.
`default_nettype none

module pid_position_controller (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire pidc_pkg::req_type                   req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output pidc_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_we,
   input  wire logic [pidc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [pidc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   typedef enum logic [11:0] {
      ST_IDLE     = 12'b0000_0000_0001,
      ST_SETUP    = 12'b0000_0000_0010,
      ST_MUL_EI   = 12'b0000_0000_0100,
      ST_CLAMP_LO = 12'b0000_0000_1000,
      ST_CLAMP_HI = 12'b0000_0001_0000,
      ST_MUL_P    = 12'b0000_0010_0000,
      ST_MUL_I    = 12'b0000_0100_0000,
      ST_DIV_I    = 12'b0000_1000_0000,
      ST_MUL_GD   = 12'b0001_0000_0000,
      ST_MUL_D    = 12'b0010_0000_0000,
      ST_DIV_D    = 12'b0100_0000_0000,
      ST_FINISH   = 12'b1000_0000_0000
   } state_type;

   // configuration
   logic signed [pidc_pkg::TGT_W-1:0]   target_ff;
   logic [pidc_pkg::GAIN_W-1:0]         gain_p_ff, gain_i_ff, gain_d_ff;
   logic signed [pidc_pkg::FLOOR_W-1:0] floor_ff;
   logic [pidc_pkg::CEIL_W-1:0]         ceiling_ff;
   logic [pidc_pkg::TMO_W-1:0]          timeout_ff;

   // control and controller state
   state_type             state_ff, state_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   pidc_pkg::err_type     last_err_ff, last_err_in;
   pidc_pkg::integ_type   integ_ff, integ_in;
   pidc_pkg::time_type    time_ff, time_in;

   // per-transaction datapath
   logic signed [pidc_pkg::POSITION_BITS-1:0] pos_ff;
   logic [pidc_pkg::EL_W-1:0]                 el_ff;
   logic                                      first_ff;
   pidc_pkg::err_type     err_ff, err_in;
   pidc_pkg::acc_type     acc_ff, acc_in;
   pidc_pkg::drv_type     drv_ff, drv_in;
   pidc_pkg::rsp_type     rsp_ff, rsp_in;

   // arithmetic units
   logic                              mul_start, div_start;
   logic [pidc_pkg::MUL_A_W-1:0]      mul_a;
   logic [pidc_pkg::MUL_B_W-1:0]      mul_b;
   logic [pidc_pkg::PROD_W-1:0]       mul_prod, div_dividend, div_quot;
   logic [pidc_pkg::EL_W-1:0]         div_divisor;
   pidc_pkg::unit_stat_type           mul_stat, div_stat;

   // helpers
   pidc_pkg::err_type                 err_c;
   logic [pidc_pkg::ERR_W-1:0]        err_mag_c, err_mag;
   pidc_pkg::diff_type                diff_c;
   logic [pidc_pkg::DIFF_W-1:0]       diff_mag;
   logic [pidc_pkg::INTEG_W-1:0]      integ_mag;
   logic [pidc_pkg::TIME_W:0]         time_sum;
   pidc_pkg::time_type                time_sat;
   pidc_pkg::acc_type                 ei_mag, ei_term, floor_ext, ceil_ext;
   pidc_pkg::drv_type                 drv_sat, drv_lim;
   logic                              timed_out, settled, move_done;
   logic                              req_fire;

   function automatic pidc_pkg::drv_type signed_term(
      input logic                         neg,
      input logic [pidc_pkg::PROD_W-1:0]  mag
   );
      pidc_pkg::drv_type m;
      m = signed'(pidc_pkg::DRV_W'(mag));
      return neg ? -m : m;
   endfunction

   pidc_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .stat  (mul_stat),
      .prod  (mul_prod)
   );

   pidc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .stat     (div_stat),
      .quotient (div_quot)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;

   always_comb begin
      err_c     = pidc_pkg::ERR_W'(target_ff) - pidc_pkg::ERR_W'(pos_ff);
      err_mag_c = err_c[pidc_pkg::ERR_W-1] ? pidc_pkg::ERR_W'(-err_c) : pidc_pkg::ERR_W'(err_c);
      err_mag   = err_ff[pidc_pkg::ERR_W-1] ? pidc_pkg::ERR_W'(-err_ff)
                                             : pidc_pkg::ERR_W'(err_ff);
      diff_c    = pidc_pkg::DIFF_W'(err_ff) - pidc_pkg::DIFF_W'(last_err_ff);
      diff_mag  = diff_c[pidc_pkg::DIFF_W-1] ? pidc_pkg::DIFF_W'(-diff_c)
                                              : pidc_pkg::DIFF_W'(diff_c);
      integ_mag = integ_ff[pidc_pkg::INTEG_W-1] ? pidc_pkg::INTEG_W'(-integ_ff)
                                                 : pidc_pkg::INTEG_W'(integ_ff);
      time_sum  = {1'b0, time_ff} + (pidc_pkg::TIME_W+1)'(el_ff);
      time_sat  = time_sum[pidc_pkg::TIME_W] ? '1 : time_sum[pidc_pkg::TIME_W-1:0];
      ei_mag    = signed'(pidc_pkg::ACC_W'(mul_prod[pidc_pkg::EI_W-1:0]));
      ei_term   = err_ff[pidc_pkg::ERR_W-1] ? -ei_mag : ei_mag;
      floor_ext = pidc_pkg::ACC_W'(floor_ff);
      ceil_ext  = signed'(pidc_pkg::ACC_W'(ceiling_ff));
      drv_lim   = signed'(pidc_pkg::DRV_W'(pidc_pkg::DRIVE_LIMIT_MV));
      if (drv_ff > drv_lim) begin
         drv_sat = drv_lim;
      end else if (drv_ff < -drv_lim) begin
         drv_sat = -drv_lim;
      end else begin
         drv_sat = drv_ff;
      end
      timed_out = (time_ff >= pidc_pkg::TIME_W'(timeout_ff));
      settled   = (err_ff == '0);
      move_done = timed_out | settled;
   end

   // sequencer: an arm entering a multiply or divide state also launches that operation
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_in       = rsp_ff;
      last_err_in  = last_err_ff;
      integ_in     = integ_ff;
      time_in      = time_ff;
      err_in       = err_ff;
      acc_in       = acc_ff;
      drv_in       = drv_ff;
      mul_start    = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            err_in = err_c;
            if (first_ff) begin
               last_err_in = '0;
               integ_in    = '0;
               time_in     = pidc_pkg::TIME_W'(el_ff);
            end else begin
               time_in = time_sat;
            end
            mul_start = 1'b1;
            mul_a     = pidc_pkg::MUL_A_W'(el_ff);
            mul_b     = pidc_pkg::MUL_B_W'(err_mag_c);
            state_in  = ST_MUL_EI;
         end
         ST_MUL_EI: begin
            if (mul_stat.done) begin
               acc_in   = pidc_pkg::ACC_W'(integ_ff) + ei_term;
               state_in = ST_CLAMP_LO;
            end
         end
         ST_CLAMP_LO: begin
            if (acc_ff < floor_ext) begin
               acc_in = floor_ext;
            end
            state_in = ST_CLAMP_HI;
         end
         ST_CLAMP_HI: begin
            // ceiling applied last, so it wins when the floor is above it
            integ_in  = (acc_ff > ceil_ext) ? ceil_ext[pidc_pkg::INTEG_W-1:0]
                                            : acc_ff[pidc_pkg::INTEG_W-1:0];
            mul_start = 1'b1;
            mul_a     = pidc_pkg::MUL_A_W'(gain_p_ff);
            mul_b     = pidc_pkg::MUL_B_W'(err_mag);
            state_in  = ST_MUL_P;
         end
         ST_MUL_P: begin
            if (mul_stat.done) begin
               drv_in    = signed_term(err_ff[pidc_pkg::ERR_W-1], mul_prod);
               mul_start = 1'b1;
               mul_a     = pidc_pkg::MUL_A_W'(integ_mag);
               mul_b     = pidc_pkg::MUL_B_W'(gain_i_ff);
               state_in  = ST_MUL_I;
            end
         end
         ST_MUL_I: begin
            if (mul_stat.done) begin
               div_start    = 1'b1;
               div_dividend = mul_prod;
               div_divisor  = pidc_pkg::EL_W'(pidc_pkg::INTEG_SCALE);
               state_in     = ST_DIV_I;
            end
         end
         ST_DIV_I: begin
            if (div_stat.done) begin
               drv_in    = drv_ff + signed_term(integ_ff[pidc_pkg::INTEG_W-1], div_quot);
               mul_start = 1'b1;
               mul_a     = pidc_pkg::MUL_A_W'(gain_d_ff);
               mul_b     = pidc_pkg::MUL_B_W'(pidc_pkg::DERIV_SCALE);
               state_in  = ST_MUL_GD;
            end
         end
         ST_MUL_GD: begin
            if (mul_stat.done) begin
               mul_start = 1'b1;
               mul_a     = mul_prod[pidc_pkg::MUL_A_W-1:0];
               mul_b     = pidc_pkg::MUL_B_W'(diff_mag);
               state_in  = ST_MUL_D;
            end
         end
         ST_MUL_D: begin
            if (mul_stat.done) begin
               // no elapsed time: derivative term stays zero
               if (el_ff == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = mul_prod;
                  div_divisor  = el_ff;
                  state_in     = ST_DIV_D;
               end
            end
         end
         ST_DIV_D: begin
            if (div_stat.done) begin
               drv_in   = drv_ff + signed_term(diff_c[pidc_pkg::DIFF_W-1], div_quot);
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_in.drive_mv = move_done ? '0 : drv_sat[pidc_pkg::DRIVE_W-1:0];
               rsp_in.done_res = move_done;
               if (timed_out) begin
                  rsp_in.end_reason = pidc_pkg::REASON_TIMEOUT;
               end else if (settled) begin
                  rsp_in.end_reason = pidc_pkg::REASON_SETTLED;
               end else begin
                  rsp_in.end_reason = pidc_pkg::REASON_RUN;
               end
               if (!move_done) begin
                  last_err_in = err_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= pidc_pkg::TARGET_RST;
         gain_p_ff    <= pidc_pkg::GAIN_P_RST;
         gain_i_ff    <= pidc_pkg::GAIN_I_RST;
         gain_d_ff    <= pidc_pkg::GAIN_D_RST;
         floor_ff     <= pidc_pkg::FLOOR_RST;
         ceiling_ff   <= pidc_pkg::CEILING_RST;
         timeout_ff   <= pidc_pkg::TIMEOUT_RST;
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         last_err_ff  <= '0;
         integ_ff     <= '0;
         time_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         last_err_ff  <= last_err_in;
         integ_ff     <= integ_in;
         time_ff      <= time_in;
         if (csr_we) begin
            case (csr_index)
               pidc_pkg::CSR_TARGET:  target_ff  <= csr_wdata[pidc_pkg::TGT_W-1:0];
               pidc_pkg::CSR_GAIN_P:  gain_p_ff  <= csr_wdata[pidc_pkg::GAIN_W-1:0];
               pidc_pkg::CSR_GAIN_I:  gain_i_ff  <= csr_wdata[pidc_pkg::GAIN_W-1:0];
               pidc_pkg::CSR_GAIN_D:  gain_d_ff  <= csr_wdata[pidc_pkg::GAIN_W-1:0];
               pidc_pkg::CSR_FLOOR:   floor_ff   <= csr_wdata[pidc_pkg::FLOOR_W-1:0];
               pidc_pkg::CSR_CEILING: ceiling_ff <= csr_wdata[pidc_pkg::CEIL_W-1:0];
               pidc_pkg::CSR_TIMEOUT: timeout_ff <= csr_wdata[pidc_pkg::TMO_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         pos_ff   <= req_data.position;
         el_ff    <= req_data.elapsed_ms;
         first_ff <= req_data.first_sample;
      end
      err_ff <= err_in;
      acc_ff <= acc_in;
      drv_ff <= drv_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_stat.busy && div_stat.busy))
      else $error("multiplier and divider busy together");

   a_accept_to_setup: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_SETUP)
      else $error("accepted transaction did not start the sequence");

   a_done_zero_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> rsp_data.drive_mv == '0)
      else $error("drive not zero on a finished move");

   a_done_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.done_res == (rsp_data.end_reason != pidc_pkg::REASON_RUN))
      else $error("done flag and end reason disagree");

   a_integ_clamped: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL_P |-> pidc_pkg::ACC_W'(integ_ff) <= ceil_ext)
      else $error("integral above ceiling after clamp");
`endif

endmodule

`default_nettype wire

>>> rtl/core/pidc_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`default_nettype none

module pidc_mul (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [pidc_pkg::MUL_A_W-1:0]      a,
   input  wire logic [pidc_pkg::MUL_B_W-1:0]      b,
   output pidc_pkg::unit_stat_type                stat,
   output logic [pidc_pkg::PROD_W-1:0]            prod
);

   logic [pidc_pkg::MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           done_ff, done_in;
   logic [pidc_pkg::MUL_A_W-1:0]   a_ff, a_in;
   logic [pidc_pkg::PROD_W-1:0]    prod_ff, prod_in;
   logic [pidc_pkg::MUL_A_W:0]     step_sum;

   // upper half accumulates, lower half holds the multiplier bits not yet used
   always_comb begin
      step_sum = {1'b0, prod_ff[pidc_pkg::PROD_W-1:pidc_pkg::MUL_B_W]}
               + (prod_ff[0] ? {1'b0, a_ff} : '0);
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      a_in    = a_ff;
      prod_in = prod_ff;
      if (start) begin
         cnt_in  = pidc_pkg::MUL_CNT_W'(pidc_pkg::MUL_B_W);
         a_in    = a;
         prod_in = pidc_pkg::PROD_W'(b);
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == pidc_pkg::MUL_CNT_W'(1));
         prod_in = {step_sum, prod_ff[pidc_pkg::MUL_B_W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      prod_ff <= prod_in;
   end

   assign stat.busy = (cnt_ff != '0);
   assign stat.done = done_ff;
   assign prod      = prod_ff;

endmodule

`default_nettype wire

>>> rtl/core/pidc_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
`default_nettype none

module pidc_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [pidc_pkg::PROD_W-1:0]    dividend,
   input  wire logic [pidc_pkg::EL_W-1:0]      divisor,
   output pidc_pkg::unit_stat_type             stat,
   output logic [pidc_pkg::PROD_W-1:0]         quotient
);

   logic [pidc_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           done_ff, done_in;
   logic [pidc_pkg::EL_W-1:0]      dvs_ff, dvs_in;
   logic [pidc_pkg::EL_W-1:0]      rem_ff, rem_in;
   logic [pidc_pkg::PROD_W-1:0]    quo_ff, quo_in;
   logic [pidc_pkg::EL_W:0]        shifted;
   logic [pidc_pkg::EL_W+1:0]      trial;
   logic                           fits;

   // dividend bits leave at the top of quo_ff while quotient bits enter at the bottom
   always_comb begin
      shifted = {rem_ff, quo_ff[pidc_pkg::PROD_W-1]};
      trial   = {1'b0, shifted} - {2'b00, dvs_ff};
      fits    = ~trial[pidc_pkg::EL_W+1];
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         cnt_in = pidc_pkg::DIV_CNT_W'(pidc_pkg::PROD_W);
         dvs_in = divisor;
         rem_in = '0;
         quo_in = dividend;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == pidc_pkg::DIV_CNT_W'(1));
         rem_in  = fits ? trial[pidc_pkg::EL_W-1:0] : shifted[pidc_pkg::EL_W-1:0];
         quo_in  = {quo_ff[pidc_pkg::PROD_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign stat.busy = (cnt_ff != '0);
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench for the PID position controller: directed table, random moves, scoreboard.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pidc_pkg::*;

   localparam longint TIME_SAT = 131071;

   typedef enum bit {ROW_SAMPLE, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      logic [CSR_IDX_W-1:0]   idx;
      logic [CSR_DATA_W-1:0]  wdata;
      req_type                sample;
      bit                     typed;
      rsp_type                want;
   } row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_type                rsp_data;
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // register copies
   longint cfg_target, cfg_gain_p, cfg_gain_i, cfg_gain_d;
   longint cfg_floor, cfg_ceiling, cfg_timeout;
   // controller state copies
   longint prev_err, integ_sum, time_total;

   rsp_type pending_drives[$];
   row_type stim_rows[$];
   int      mismatch_count = 0;
   int      items_sent = 0;
   int      rsp_seen = 0;
   bit      no_idle = 1'b0;

   pid_position_controller u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic rsp_type predict_drive(req_type s);
      longint pos, el, err, diff, d_term, p_term, i_term, acc, sum;
      rsp_type r;
      pos = $signed(s.position);
      el  = s.elapsed_ms;
      if (s.first_sample) begin
         integ_sum  = 0;
         prev_err   = 0;
         time_total = 0;
      end
      err = cfg_target - pos;
      time_total += el;
      if (time_total > TIME_SAT) time_total = TIME_SAT;
      diff = err - prev_err;
      d_term = 0;
      if (el != 0) d_term = (cfg_gain_d * diff * 1000) / el;
      acc = integ_sum + err * el;
      // floor first, ceiling last, so ceiling wins when they cross
      if (acc < cfg_floor) acc = cfg_floor;
      if (acc > cfg_ceiling) acc = cfg_ceiling;
      integ_sum = acc;
      p_term = cfg_gain_p * err;
      i_term = (cfg_gain_i * integ_sum) / 1000;
      sum = p_term + i_term + d_term;
      if (sum > DRIVE_LIMIT_MV) sum = DRIVE_LIMIT_MV;
      if (sum < -DRIVE_LIMIT_MV) sum = -DRIVE_LIMIT_MV;
      r.done_res   = 1'b0;
      r.end_reason = REASON_RUN;
      if (time_total >= cfg_timeout) begin
         r.done_res   = 1'b1;
         r.end_reason = REASON_TIMEOUT;
      end else if (err == 0) begin
         r.done_res   = 1'b1;
         r.end_reason = REASON_SETTLED;
      end
      if (r.done_res) sum = 0;
      else prev_err = err;
      r.drive_mv = sum[DRIVE_W-1:0];
      return r;
   endfunction

   task automatic flag_mismatch(string what, int got, int want);
      $display("%0t rsp #%0d mismatch on %s: got %0d want %0d", $time, rsp_seen, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : rsp_monitor
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_drives.size() == 0) begin
            flag_mismatch("unexpected transaction", int'(rsp_data.drive_mv), 0);
         end else begin
            want = pending_drives.pop_front();
            if (rsp_data.drive_mv !== want.drive_mv)
               flag_mismatch("drive_mv", int'(rsp_data.drive_mv), int'(want.drive_mv));
            if (rsp_data.done_res !== want.done_res)
               flag_mismatch("done_res", int'(rsp_data.done_res), int'(want.done_res));
            if (rsp_data.end_reason !== want.end_reason)
               flag_mismatch("end_reason", int'(rsp_data.end_reason), int'(want.end_reason));
         end
         rsp_seen++;
      end
   end

   // receiver: random stall bursts, none in the closing phase
   initial begin
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!no_idle && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 250)) @(posedge clock);
      end
   end

   task automatic send_sample(req_type s, bit typed, rsp_type want);
      rsp_type r;
      csr_we <= 1'b0;
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= s;
      do @(posedge clock); while (!req_ready);
      r = predict_drive(s);
      pending_drives.push_back(typed ? want : r);
      items_sent++;
   endtask

   // hold off the sender until every outstanding transaction has returned
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_drives.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_TARGET:  cfg_target  = $signed(data[TGT_W-1:0]);
         CSR_GAIN_P:  cfg_gain_p  = data[GAIN_W-1:0];
         CSR_GAIN_I:  cfg_gain_i  = data[GAIN_W-1:0];
         CSR_GAIN_D:  cfg_gain_d  = data[GAIN_W-1:0];
         CSR_FLOOR:   cfg_floor   = $signed(data[FLOOR_W-1:0]);
         CSR_CEILING: cfg_ceiling = data[CEIL_W-1:0];
         CSR_TIMEOUT: cfg_timeout = data[TMO_W-1:0];
         default: ;
      endcase
   endtask

   function automatic req_type make_sample(int pos, int el, bit first);
      req_type s;
      s.position     = 16'(pos);
      s.elapsed_ms   = 16'(el);
      s.first_sample = first;
      return s;
   endfunction

   function automatic void add_sample(int pos, int el, bit first);
      row_type row;
      row.kind   = ROW_SAMPLE;
      row.sample = make_sample(pos, el, first);
      row.typed  = 1'b0;
      row.want   = '0;
      stim_rows.push_back(row);
   endfunction

   function automatic void add_typed(int pos, int el, bit first,
                                     int drive, bit done, logic [REASON_W-1:0] reason);
      row_type row;
      row.kind            = ROW_SAMPLE;
      row.sample          = make_sample(pos, el, first);
      row.typed           = 1'b1;
      row.want.drive_mv   = 15'(drive);
      row.want.done_res   = done;
      row.want.end_reason = reason;
      stim_rows.push_back(row);
   endfunction

   function automatic void add_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      row_type row;
      row.kind  = ROW_CSR;
      row.idx   = idx;
      row.wdata = data;
      row.typed = 1'b0;
      row.want  = '0;
      stim_rows.push_back(row);
   endfunction

   // mode 0 gives the low end, 1 the high end, anything else the typical value
   function automatic logic [31:0] pick(int mode, logic [31:0] lo, logic [31:0] hi,
                                        logic [31:0] typical);
      if (mode == 0) return lo;
      if (mode == 1) return hi;
      return typical;
   endfunction

   task automatic randomize_config();
      logic [31:0] g;
      drain_results();
      csr_write(CSR_TARGET, pick($urandom_range(0, 5), 32'h8000, 32'h7fff, $urandom()));
      g = ($urandom_range(0, 3) == 0) ? $urandom() : {16'($urandom()), 16'($urandom_range(0, 400))};
      csr_write(CSR_GAIN_P, pick($urandom_range(0, 5), 32'h0, 32'hffff, g));
      g = ($urandom_range(0, 3) == 0) ? $urandom() : {16'($urandom()), 16'($urandom_range(0, 400))};
      csr_write(CSR_GAIN_I, pick($urandom_range(0, 5), 32'h0, 32'hffff, g));
      g = ($urandom_range(0, 3) == 0) ? $urandom() : {16'($urandom()), 16'($urandom_range(0, 400))};
      csr_write(CSR_GAIN_D, pick($urandom_range(0, 5), 32'h0, 32'hffff, g));
      g = ($urandom_range(0, 3) == 0) ? ($urandom() | 32'h8000_0000)
                                      : 32'(-int'($urandom_range(0, 400000)));
      csr_write(CSR_FLOOR, pick($urandom_range(0, 5), 32'h8000_0000, 32'h0, g));
      g = ($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(0, 400000));
      csr_write(CSR_CEILING, pick($urandom_range(0, 5), 32'h0, 32'h7fff_ffff, g));
      g = {16'($urandom()), 16'($urandom_range(20, 3000))};
      csr_write(CSR_TIMEOUT, pick($urandom_range(0, 7), 32'h0, 32'hffff, g));
   endtask

   // a well-formed move: first sample, then positions closing in on the target
   task automatic run_move(int room);
      int len, pos, el;
      req_type s;
      len = $urandom_range(3, 60);
      if (len > room) len = room;
      pos = int'($urandom_range(0, 65535)) - 32768;
      for (int k = 0; k < len; k++) begin
         if (k > 0) begin
            pos = pos + (int'(cfg_target) - pos) / int'($urandom_range(2, 6))
                  + int'($urandom_range(0, 6)) - 3;
            if ($urandom_range(0, 7) == 0) pos = int'(cfg_target);
            if (pos > 32767) pos = 32767;
            if (pos < -32768) pos = -32768;
            el = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 25);
         end else begin
            el = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 30) : 0;
         end
         s = make_sample(pos, el, k == 0);
         send_sample(s, 1'b0, '0);
      end
   endtask

   initial begin
      int phase_end;
      req_type s;
      bit prev_was_sample;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = CSR_TARGET;
      csr_wdata = '0;
      cfg_target  = TARGET_RST;
      cfg_gain_p  = GAIN_P_RST;
      cfg_gain_i  = GAIN_I_RST;
      cfg_gain_d  = GAIN_D_RST;
      cfg_floor   = FLOOR_RST;
      cfg_ceiling = CEILING_RST;
      cfg_timeout = TIMEOUT_RST;
      prev_err    = 0;
      integ_sum   = 0;
      time_total  = 0;

      // reset defaults: settle, saturation both ways, zero elapsed time
      add_typed(0, 0, 1, 0, 1'b1, REASON_SETTLED);
      add_typed(-32768, 0, 1, 12000, 1'b0, REASON_RUN);
      add_typed(32767, 0, 1, -12000, 1'b0, REASON_RUN);
      add_typed(1, 0, 0, -100, 1'b0, REASON_RUN);
      add_sample(-1000, 10, 1);
      add_sample(-990, 10, 0);
      add_sample(-400, 1, 0);
      add_sample(-5, 65535, 0);
      // timeout, repeated done, saturating time
      add_typed(0, 65535, 1, 0, 1'b1, REASON_TIMEOUT);
      add_typed(7, 65535, 0, 0, 1'b1, REASON_TIMEOUT);
      add_typed(7, 65535, 0, 0, 1'b1, REASON_TIMEOUT);
      // zero timeout beats a settled error
      add_csr(CSR_TIMEOUT, 32'h0);
      add_typed(100, 0, 1, 0, 1'b1, REASON_TIMEOUT);
      add_typed(0, 0, 0, 0, 1'b1, REASON_TIMEOUT);
      // max gains, floor above ceiling
      add_csr(CSR_TARGET, 32'h7fff);
      add_csr(CSR_GAIN_P, 32'hffff);
      add_csr(CSR_GAIN_I, 32'hffff);
      add_csr(CSR_GAIN_D, 32'hffff);
      add_csr(CSR_FLOOR, 32'd50000);
      add_csr(CSR_CEILING, 32'd20000);
      add_csr(CSR_TIMEOUT, 32'hffff);
      add_sample(-32768, 0, 1);
      add_sample(32767, 1, 0);
      add_sample(0, 3, 0);
      add_sample(32000, 1, 0);
      add_sample(-32768, 2, 0);
      // zero gains, widest clamps
      add_csr(CSR_TARGET, 32'h8000);
      add_csr(CSR_GAIN_P, 32'h0);
      add_csr(CSR_GAIN_I, 32'h0);
      add_csr(CSR_GAIN_D, 32'h0);
      add_csr(CSR_FLOOR, 32'h8000_0000);
      add_csr(CSR_CEILING, 32'h7fff_ffff);
      add_typed(32767, 1, 1, 0, 1'b0, REASON_RUN);
      add_sample(-32768, 100, 0);
      // ceiling upper bit dropped, integral driven toward its ceiling
      add_csr(CSR_TARGET, 32'h0);
      add_csr(CSR_GAIN_I, 32'd1000);
      add_csr(CSR_FLOOR, 32'hffff_ffff);
      add_csr(CSR_CEILING, 32'hffff_ffff);
      add_sample(-32768, 40000, 1);
      add_sample(-32768, 20000, 0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      prev_was_sample = 1'b0;
      foreach (stim_rows[n]) begin
         if (stim_rows[n].kind == ROW_CSR) begin
            if (prev_was_sample) drain_results();
            csr_write(stim_rows[n].idx, stim_rows[n].wdata);
            prev_was_sample = 1'b0;
         end else begin
            send_sample(stim_rows[n].sample, stim_rows[n].typed, stim_rows[n].want);
            prev_was_sample = 1'b1;
         end
      end

      for (int phase = 0; phase < 8; phase++) begin
         randomize_config();
         if (phase == 7) no_idle = 1'b1;
         phase_end = items_sent + 244;
         while (items_sent < phase_end) begin
            if ($urandom_range(0, 4) == 0) begin
               // noise: anything the fields allow
               s.position     = 16'($urandom());
               s.elapsed_ms   = 16'($urandom());
               s.first_sample = 1'($urandom_range(0, 1));
               send_sample(s, 1'b0, '0);
            end else begin
               run_move(phase_end - items_sent);
            end
         end
      end

      drain_results();
      repeat (250) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire
